// ===== hw/rtl/ilc_pkg.sv =====
// Shared types, register indexes and command codes for the integrator plus lead compensator.
package ilc_pkg;

	localparam int PORT_W    = 32;
	localparam int PROD_W    = 2 * PORT_W;
	localparam int ACC_W     = PROD_W + 4;
	localparam int CFG_IDX_W = 4;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_REF   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNS = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B0    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_B1    = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_B2    = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_A1    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_A2    = 4'd7;

	localparam logic [3:0] SIGNS_RESET = 4'd10;

	// sum_signs bit positions, set means subtract
	localparam int SGN_REF = 0;
	localparam int SGN_Y1  = 1;
	localparam int SGN_U1  = 2;
	localparam int SGN_Y2  = 3;

	// multiplier operand pair
	typedef logic [2:0] mul_sel_t;
	localparam mul_sel_t MUL_GAIN = 3'd0;
	localparam mul_sel_t MUL_B0   = 3'd1;
	localparam mul_sel_t MUL_B1   = 3'd2;
	localparam mul_sel_t MUL_B2   = 3'd3;
	localparam mul_sel_t MUL_A1   = 3'd4;
	localparam mul_sel_t MUL_A2   = 3'd5;

	// accumulator operation
	typedef logic [1:0] acc_op_t;
	localparam acc_op_t ACC_HOLD      = 2'd0;
	localparam acc_op_t ACC_LOAD_INT  = 2'd1;
	localparam acc_op_t ACC_ADD       = 2'd2;
	localparam acc_op_t ACC_LOAD_PROD = 2'd3;

	typedef struct packed {
		logic signed [PORT_W-1:0] ref_position;
		logic signed [PORT_W-1:0] integrator_gain;
		logic [3:0]               sum_signs;
		logic signed [PORT_W-1:0] num_b0;
		logic signed [PORT_W-1:0] num_b1;
		logic signed [PORT_W-1:0] num_b2;
		logic signed [PORT_W-1:0] den_a1;
		logic signed [PORT_W-1:0] den_a2;
	} cfg_t;

	typedef struct packed {
		logic     ld_in;
		logic     ld_e1;
		logic     ld_u1;
		logic     ld_e2;
		logic     commit;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
	} cmd_t;

endpackage

// ===== hw/rtl/ilc_intf.sv =====
// Channel interfaces: position sample, result, configuration write.
interface ilc_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [ilc_pkg::PORT_W-1:0] estimated_position;

	modport source (output valid, output estimated_position, input ready);
	modport sink (input valid, input estimated_position, output ready);
endinterface

interface ilc_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [ilc_pkg::PORT_W-1:0] drive_value;
	logic signed [ilc_pkg::PORT_W-1:0] integrator_value;
	logic                              saturated;

	modport source (output valid, output drive_value, output integrator_value,
		output saturated, input ready);
	modport sink (input valid, input drive_value, input integrator_value,
		input saturated, output ready);
endinterface

interface ilc_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [ilc_pkg::CFG_IDX_W-1:0]       index;
	logic [ilc_pkg::PORT_W-1:0]          data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/integrator_lead_compensator.sv =====
// Top level: integrator followed by a second-order lead section, fixed point.
//
//  channel  dir  handshake    payload
//  sample   in   valid/ready  estimated_position
//  result   out  valid/ready  drive_value, integrator_value, saturated
//  cfg      in   valid/ready  index, data (ready always high)
//
// An item runs from the accept cycle through eight steps on the single 32x32 multiplier
// and its accumulator, six products in all; result valid is registered from the last step.
// sample.ready is high only between items, so a new item waits until the last one commits.
// A result waiting in the output register does not block acceptance; the last step
// holds only while that register is still full. Reset clears the filter history,
// the output valid and the registers to their defaults.
module integrator_lead_compensator #(
	parameter int DATA_WIDTH     = 32,
	parameter int COEF_FRAC_BITS = 24
) (
	input logic      clk,
	input logic      arst_n,
	ilc_in_if.sink   sample,
	ilc_out_if.source result,
	ilc_cfg_if.sink  cfg
);
	import ilc_pkg::*;

	localparam int SIG_W = (DATA_WIDTH < PORT_W) ? DATA_WIDTH : PORT_W;
	localparam logic signed [PORT_W-1:0] OUT_HI =
		PORT_W'((PROD_W'(1) <<< (SIG_W - 1)) - PROD_W'(1));
	localparam logic signed [PORT_W-1:0] OUT_LO = -OUT_HI - PORT_W'(1);

	cfg_t cfg_regs;
	cmd_t cmd;

	assign cfg.ready = 1'b1;

	ilc_cfg_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	ilc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	ilc_dp #(
		.SIG_W          (SIG_W),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_regs),
		.cmd              (cmd),
		.in_position      (sample.estimated_position),
		.drive_value      (result.drive_value),
		.integrator_value (result.integrator_value),
		.saturated        (result.saturated)
	);

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> !sample.ready)
		else $error("sample accepted while an item is in progress");

	// with an empty output register the last step does not stall before the result shows
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready && !result.valid) |-> ##9 result.valid)
		else $error("result did not appear after nine cycles");

	// saturation keeps both outputs within the signal range
	a_output_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.drive_value <= OUT_HI && result.drive_value >= OUT_LO
			&& result.integrator_value <= OUT_HI && result.integrator_value >= OUT_LO))
		else $error("output outside the saturated signal range");

endmodule

// ===== hw/rtl/ilc_cfg_regs.sv =====
// Configuration register file of the compensator.
module ilc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [ilc_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [ilc_pkg::PORT_W-1:0]    wr_data,
	output ilc_pkg::cfg_t                 cfg
);
	import ilc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ref_position    <= '0;
			cfg_q.integrator_gain <= '0;
			cfg_q.sum_signs       <= SIGNS_RESET;
			cfg_q.num_b0          <= '0;
			cfg_q.num_b1          <= '0;
			cfg_q.num_b2          <= '0;
			cfg_q.den_a1          <= '0;
			cfg_q.den_a2          <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_REF:   cfg_q.ref_position    <= wr_data;
				REG_GAIN:  cfg_q.integrator_gain <= wr_data;
				REG_SIGNS: cfg_q.sum_signs       <= wr_data[3:0];
				REG_B0:    cfg_q.num_b0          <= wr_data;
				REG_B1:    cfg_q.num_b1          <= wr_data;
				REG_B2:    cfg_q.num_b2          <= wr_data;
				REG_A1:    cfg_q.den_a1          <= wr_data;
				REG_A2:    cfg_q.den_a2          <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/ilc_ctrl.sv =====
// Step sequencer: walks one item through the shared multiply-accumulate datapath.
module ilc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output ilc_pkg::cmd_t cmd
);
	import ilc_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_E1     = 4'd1;
	localparam logic [3:0] ST_U1_ACC = 4'd2;
	localparam logic [3:0] ST_U1     = 4'd3;
	localparam logic [3:0] ST_E2     = 4'd4;
	localparam logic [3:0] ST_MAC_A  = 4'd5;
	localparam logic [3:0] ST_MAC_B  = 4'd6;
	localparam logic [3:0] ST_MAC_C  = 4'd7;
	localparam logic [3:0] ST_U2     = 4'd8;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = MUL_GAIN;
		cmd.acc_op  = ACC_HOLD;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					state_d   = ST_E1;
				end
			end
			ST_E1: begin
				cmd.ld_e1   = 1'b1;
				cmd.acc_op  = ACC_LOAD_INT;
				cmd.mul_sel = MUL_GAIN;
				state_d     = ST_U1_ACC;
			end
			ST_U1_ACC: begin
				cmd.acc_op  = ACC_ADD;
				cmd.mul_sel = MUL_B1;
				state_d     = ST_U1;
			end
			ST_U1: begin
				// integrator sum done; start the lead sum with the b1 product
				cmd.ld_u1   = 1'b1;
				cmd.acc_op  = ACC_LOAD_PROD;
				cmd.mul_sel = MUL_B2;
				state_d     = ST_E2;
			end
			ST_E2: begin
				cmd.ld_e2   = 1'b1;
				cmd.acc_op  = ACC_ADD;
				cmd.mul_sel = MUL_A1;
				state_d     = ST_MAC_A;
			end
			ST_MAC_A: begin
				cmd.acc_op  = ACC_ADD;
				cmd.mul_sel = MUL_A2;
				state_d     = ST_MAC_B;
			end
			ST_MAC_B: begin
				cmd.acc_op  = ACC_ADD;
				cmd.mul_sel = MUL_B0;
				state_d     = ST_MAC_C;
			end
			ST_MAC_C: begin
				cmd.acc_op = ACC_ADD;
				state_d    = ST_U2;
			end
			ST_U2: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.commit || (out_valid_q && !out_ready);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/ilc_dp.sv =====
// Datapath: summers, shared 32x32 multiplier, wide accumulator, history and result registers.
module ilc_dp #(
	parameter int SIG_W          = 32,
	parameter int COEF_FRAC_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ilc_pkg::cfg_t                     cfg,
	input  ilc_pkg::cmd_t                     cmd,
	input  logic signed [ilc_pkg::PORT_W-1:0] in_position,
	output logic signed [ilc_pkg::PORT_W-1:0] drive_value,
	output logic signed [ilc_pkg::PORT_W-1:0] integrator_value,
	output logic                              saturated
);
	import ilc_pkg::*;

	localparam logic signed [ACC_W-1:0] SAT_HI =
		ACC_W'((ACC_W'(1) <<< (SIG_W - 1)) - ACC_W'(1));
	localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

	function automatic logic signed [PORT_W-1:0] sat_fn(
		input  logic signed [ACC_W-1:0] v,
		output logic                    clip
	);
		clip = 1'b1;
		if (v > SAT_HI) return PORT_W'(SAT_HI);
		if (v < SAT_LO) return PORT_W'(SAT_LO);
		clip = 1'b0;
		return PORT_W'(v);
	endfunction

	function automatic logic signed [ACC_W-1:0] sum2(
		input logic signed [PORT_W-1:0] a,
		input logic                     neg_a,
		input logic signed [PORT_W-1:0] b,
		input logic                     neg_b
	);
		logic signed [ACC_W-1:0] xa;
		logic signed [ACC_W-1:0] xb;
		xa = neg_a ? -ACC_W'(a) : ACC_W'(a);
		xb = neg_b ? -ACC_W'(b) : ACC_W'(b);
		return xa + xb;
	endfunction

	logic signed [PORT_W-1:0] y_q;
	logic signed [PORT_W-1:0] e1_q, u1_q, e2_q;
	logic signed [PORT_W-1:0] prev_e1_q, integ_q;
	logic signed [PORT_W-1:0] eh0_q, eh1_q, dh0_q, dh1_q;
	logic                     clip_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_s1;

	logic signed [PORT_W-1:0] mul_a, mul_b;
	logic signed [PORT_W-1:0] e1_d, u1_d, e2_d, u2_d;
	logic                     e1_clip, u1_clip, e2_clip, u2_clip;
	logic signed [ACC_W-1:0]  acc_shr;

	always_comb begin
		case (cmd.mul_sel)
			MUL_GAIN: begin mul_a = prev_e1_q; mul_b = cfg.integrator_gain; end
			MUL_B0:   begin mul_a = e2_q;      mul_b = cfg.num_b0;          end
			MUL_B1:   begin mul_a = eh0_q;     mul_b = cfg.num_b1;          end
			MUL_B2:   begin mul_a = eh1_q;     mul_b = cfg.num_b2;          end
			MUL_A1:   begin mul_a = dh0_q;     mul_b = cfg.den_a1;          end
			MUL_A2:   begin mul_a = dh1_q;     mul_b = cfg.den_a2;          end
			default:  begin mul_a = '0;        mul_b = '0;                  end
		endcase
	end

	// arithmetic shift floors, matching the exact sum of products
	assign acc_shr = acc_q >>> COEF_FRAC_BITS;

	always_comb begin
		e1_d = sat_fn(sum2(cfg.ref_position, cfg.sum_signs[SGN_REF],
			y_q, cfg.sum_signs[SGN_Y1]), e1_clip);
		u1_d = sat_fn(acc_shr, u1_clip);
		e2_d = sat_fn(sum2(u1_q, cfg.sum_signs[SGN_U1],
			y_q, cfg.sum_signs[SGN_Y2]), e2_clip);
		u2_d = sat_fn(acc_shr, u2_clip);
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		if (cmd.ld_in) y_q <= in_position;
		if (cmd.ld_e1) e1_q <= e1_d;
		if (cmd.ld_u1) u1_q <= u1_d;
		if (cmd.ld_e2) e2_q <= e2_d;
		case (cmd.acc_op)
			// integrator value pre-scaled so one floor shift gives acc + floor(p)
			ACC_LOAD_INT:  acc_q <= ACC_W'(integ_q) <<< COEF_FRAC_BITS;
			ACC_ADD:       acc_q <= acc_q + ACC_W'(prod_s1);
			ACC_LOAD_PROD: acc_q <= ACC_W'(prod_s1);
			default:       acc_q <= acc_q;
		endcase
		if (cmd.ld_e1) begin
			clip_q <= e1_clip;
		end else if (cmd.ld_u1) begin
			clip_q <= clip_q | u1_clip;
		end else if (cmd.ld_e2) begin
			clip_q <= clip_q | e2_clip;
		end
		if (cmd.commit) begin
			drive_value      <= u2_d;
			integrator_value <= u1_q;
			saturated        <= clip_q | u2_clip;
		end
	end

	// filter state, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_e1_q <= '0;
			integ_q   <= '0;
			eh0_q     <= '0;
			eh1_q     <= '0;
			dh0_q     <= '0;
			dh1_q     <= '0;
		end else if (cmd.commit) begin
			prev_e1_q <= e1_q;
			integ_q   <= u1_q;
			eh1_q     <= eh0_q;
			eh0_q     <= e2_q;
			dh1_q     <= dh0_q;
			dh0_q     <= u2_d;
		end
	end

endmodule

// ===== dv/ilc_loop_checker.sv =====
// Watches the sample, result and register channels, predicts every result and compares.
`timescale 1ns / 1ps

module ilc_loop_checker #(
	parameter int FRAC = 24
) (
	input  logic clk,
	input  logic arst_n,
	ilc_in_if    sample,
	ilc_out_if   result,
	ilc_cfg_if   cfg,
	output int   errors,
	output int   pending
);
	import ilc_pkg::*;

	typedef logic signed [71:0] wide_t;
	typedef logic signed [31:0] sig_t;

	typedef struct packed {
		sig_t drive;
		sig_t integ;
		logic clip;
	} loop_out_t;

	localparam sig_t SIG_MAX = 32'sh7fff_ffff;
	localparam sig_t SIG_MIN = 32'sh8000_0000;

	cfg_t      regs;
	sig_t      last_e1;
	sig_t      integ_acc;
	sig_t      e2_d1, e2_d2;
	sig_t      u2_d1, u2_d2;
	loop_out_t drive_expected[$];
	int        results_seen;

	function automatic wide_t widen(input sig_t v);
		return v;
	endfunction

	function automatic sig_t clip_sig(input wide_t v);
		if (v > widen(SIG_MAX))
			return SIG_MAX;
		if (v < widen(SIG_MIN))
			return SIG_MIN;
		return v[31:0];
	endfunction

	// One control tick: summer, integrator, summer, lead section; updates the history.
	function automatic loop_out_t step_loop(input sig_t y);
		wide_t     yw, e1w, u1w, e2w, lead;
		sig_t      e1, u1, e2, u2;
		logic      clip;
		loop_out_t r;
		yw = widen(y);
		clip = 1'b0;

		e1w = (regs.sum_signs[SGN_REF] ? -widen(regs.ref_position) : widen(regs.ref_position))
			+ (regs.sum_signs[SGN_Y1] ? -yw : yw);
		e1 = clip_sig(e1w);
		clip |= (widen(e1) != e1w);

		// integrator uses last tick's error
		u1w = widen(integ_acc) + ((widen(last_e1) * widen(regs.integrator_gain)) >>> FRAC);
		u1 = clip_sig(u1w);
		clip |= (widen(u1) != u1w);

		e2w = (regs.sum_signs[SGN_U1] ? -widen(u1) : widen(u1))
			+ (regs.sum_signs[SGN_Y2] ? -yw : yw);
		e2 = clip_sig(e2w);
		clip |= (widen(e2) != e2w);

		lead = widen(e2) * widen(regs.num_b0)
			+ widen(e2_d1) * widen(regs.num_b1)
			+ widen(e2_d2) * widen(regs.num_b2)
			+ widen(u2_d1) * widen(regs.den_a1)
			+ widen(u2_d2) * widen(regs.den_a2);
		lead = lead >>> FRAC;
		u2 = clip_sig(lead);
		clip |= (widen(u2) != lead);

		last_e1 = e1;
		integ_acc = u1;
		e2_d2 = e2_d1;
		e2_d1 = e2;
		u2_d2 = u2_d1;
		u2_d1 = u2;

		r.drive = u2;
		r.integ = u1;
		r.clip = clip;
		return r;
	endfunction

	task automatic report(input string field, input sig_t got, input sig_t want);
		if (errors < 100)
			$display("%0t result %0d: %s got %0d expected %0d",
				$realtime, results_seen, field, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		loop_out_t want;
		if (!arst_n) begin
			regs = '0;
			regs.sum_signs = SIGNS_RESET;
			last_e1 = '0;
			integ_acc = '0;
			e2_d1 = '0;
			e2_d2 = '0;
			u2_d1 = '0;
			u2_d2 = '0;
			drive_expected.delete();
			results_seen = 0;
			errors = 0;
			pending = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (drive_expected.size() == 0) begin
					report("drive_value with no item outstanding", result.drive_value, '0);
				end else begin
					want = drive_expected.pop_front();
					if (result.drive_value !== want.drive)
						report("drive_value", result.drive_value, want.drive);
					if (result.integrator_value !== want.integ)
						report("integrator_value", result.integrator_value, want.integ);
					if (result.saturated !== want.clip)
						report("saturated", sig_t'(result.saturated), sig_t'(want.clip));
				end
				results_seen++;
			end
			if (sample.valid && sample.ready)
				drive_expected.push_back(step_loop(sample.estimated_position));
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_REF:   regs.ref_position = cfg.data;
					REG_GAIN:  regs.integrator_gain = cfg.data;
					REG_SIGNS: regs.sum_signs = cfg.data[3:0];
					REG_B0:    regs.num_b0 = cfg.data;
					REG_B1:    regs.num_b1 = cfg.data;
					REG_B2:    regs.num_b2 = cfg.data;
					REG_A1:    regs.den_a1 = cfg.data;
					REG_A2:    regs.den_a2 = cfg.data;
					default:   ;
				endcase
			end
			pending = drive_expected.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
// Top of the compensator testbench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module testbench;
	import ilc_pkg::*;

	localparam int COEF_FRAC = 24;
	localparam int LIMIT     = 300000;

	localparam logic [31:0] P_MAX = 32'h7fff_ffff;
	localparam logic [31:0] P_MIN = 32'h8000_0000;
	localparam logic [31:0] UNITY = 32'h0100_0000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int   fail_count;
	int   pending;
	int   burst_left = 0;
	int   rx_hold = 0;
	int   cycle_count;
	logic tx_free = 1'b0;
	logic rx_free = 1'b0;

	ilc_in_if  sample();
	ilc_out_if result();
	ilc_cfg_if cfg();

	integrator_lead_compensator #(
		.DATA_WIDTH(32),
		.COEF_FRAC_BITS(COEF_FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample),
		.result(result),
		.cfg(cfg)
	);

	ilc_loop_checker #(
		.FRAC(COEF_FRAC)
	) loop_check (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample),
		.result(result),
		.cfg(cfg),
		.errors(fail_count),
		.pending(pending)
	);

	always #5 clk = ~clk;

	// receiver: runs of ready and stalls, now and then a long stall
	always @(posedge clk) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			rx_hold = 0;
		end else if (rx_free) begin
			result.ready <= 1'b1;
		end else if (rx_hold > 0) begin
			rx_hold--;
		end else begin
			if (result.ready)
				rx_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
					: $urandom_range(0, 5);
			else
				rx_hold = $urandom_range(0, 12);
			result.ready <= !result.ready;
		end
	end

	function automatic logic [31:0] corner32();
		case ($urandom_range(0, 4))
			0:       return P_MAX;
			1:       return P_MIN;
			2:       return 32'h0000_0000;
			3:       return 32'h0000_0001;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	// signed random value within +/- 2^bits
	function automatic logic [31:0] span(input int bits);
		logic [31:0] r;
		r = $urandom_range(0, (1 << (bits + 1)) - 1);
		return r - 32'(1 << bits);
	endfunction

	function automatic logic [31:0] pick_position();
		case ($urandom_range(0, 9))
			0:       return corner32();
			1, 2, 3: return $urandom;
			default: return span(27);
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic set_registers(input logic [31:0] ref_pos, gain, signs, b0, b1, b2, a1, a2);
		write_reg(REG_REF, ref_pos);
		write_reg(REG_GAIN, gain);
		write_reg(REG_SIGNS, signs);
		write_reg(REG_B0, b0);
		write_reg(REG_B1, b1);
		write_reg(REG_B2, b2);
		write_reg(REG_A1, a1);
		write_reg(REG_A2, a2);
		cfg.valid <= 1'b0;
	endtask

	// 0: corners, 1: full random, 2: moderate loop that does not rail at once
	task automatic random_setting(input int style);
		logic [31:0] v[8];
		for (int i = 0; i < 8; i++) begin
			case (style)
				0:       v[i] = corner32();
				1:       v[i] = $urandom;
				default: v[i] = span(25);
			endcase
		end
		if (style == 2) begin
			v[1] = span(21);
			v[6] = span(24);
			v[7] = span(23);
		end
		// sum_signs keeps only its low bits; junk above them
		v[2] = {28'($urandom_range(0, 32'h0fff_ffff)), 4'($urandom_range(0, 15))};
		if ($urandom_range(0, 2) == 0)
			write_reg(CFG_IDX_W'($urandom_range(8, 15)), $urandom);
		set_registers(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
	endtask

	task automatic send_position(input logic [31:0] pos);
		int gap;
		if (!tx_free && burst_left == 0) begin
			sample.valid <= 1'b0;
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 8);
		end
		sample.valid <= 1'b1;
		sample.estimated_position <= pos;
		do @(posedge clk); while (!sample.ready);
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic send_list(input logic [31:0] list[$]);
		foreach (list[i])
			send_position(list[i]);
		sample.valid <= 1'b0;
	endtask

	task automatic run_phase(input int n_items);
		for (int i = 0; i < n_items; i++)
			send_position(pick_position());
		sample.valid <= 1'b0;
	endtask

	// block idle: every item answered, then a margin before the next phase
	task automatic wait_idle();
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("integrator_lead_compensator regression: fail");
		$finish;
	end

	initial begin
		logic [31:0] few[$];
		sample.valid <= 1'b0;
		sample.estimated_position <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= '0;
		cfg.data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: subtracting y, so y at its minimum clips the first summer
		send_list('{P_MAX, P_MIN, 32'h0, 32'hffff_ffff, 32'h1});
		wait_idle();

		// all adds, big gain: summer overflow and integrator windup
		set_registers(P_MAX, P_MAX, 32'h0, UNITY, 32'h0, 32'h0, 32'h0, 32'h0);
		send_list('{P_MAX, P_MAX, P_MAX, P_MIN, P_MIN, 32'h0});
		wait_idle();

		// coefficient extremes, all subtracts, writes to unused indexes
		write_reg(CFG_IDX_W'(8), 32'hdead_beef);
		write_reg(CFG_IDX_W'(15), 32'h1234_5678);
		set_registers(P_MIN, P_MIN, 32'hffff_ffff, P_MIN, P_MAX, P_MIN, P_MAX, P_MIN);
		send_list('{P_MIN, P_MAX, 32'hffff_ffff, 32'h1, P_MIN, P_MAX});
		wait_idle();

		// well-behaved lead section with small signals
		set_registers(32'h0100_0000, 32'h0010_0000, 32'h0000_00a3, UNITY, 32'hff80_0000,
			32'h0040_0000, 32'h0080_0000, 32'hffc0_0000);
		for (int i = 0; i < 6; i++)
			few.push_back(span(26));
		send_list(few);

		for (int p = 0; p < 12; p++) begin
			wait_idle();
			tx_free = (p % 5 == 3);
			rx_free = (p % 5 == 3);
			random_setting((p % 4 == 0) ? 0 : $urandom_range(1, 2));
			run_phase(50);
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("integrator_lead_compensator regression: pass");
		else
			$display("integrator_lead_compensator regression: fail");
		$finish;
	end

endmodule
